>>> hdl/fdes_pkg.sv
// ----------------------------------------------------------------------------
// fdes_pkg
// Shared types and constants for the FAT directory entry scanner.
// ----------------------------------------------------------------------------
package fdes_pkg;

   // Result status codes
   typedef enum logic [2:0] {
      STATUS_SKIPPED  = 3'd0,
      STATUS_COUNTED  = 3'd1,
      STATUS_MATCH    = 3'd2,
      STATUS_END      = 3'd3,
      STATUS_DONE     = 3'd4
   } status_type;

   // Search modes
   typedef enum logic [1:0] {
      MODE_LIST   = 2'd0,
      MODE_INDEX  = 2'd1,
      MODE_FILE   = 2'd2,
      MODE_FOLDER = 2'd3
   } mode_type;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SEARCH_MODE   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TARGET_NAME   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TARGET_EXT    = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PREFIX_LENGTH = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TARGET_INDEX  = 3'd4;
   localparam int unsigned CSR_DATA_WIDTH = 64;

   // Field widths
   localparam int unsigned NAME_WIDTH    = 64;
   localparam int unsigned NAME_BYTES    = 8;
   localparam int unsigned EXT_WIDTH     = 24;
   localparam int unsigned ATTR_WIDTH    = 8;
   localparam int unsigned CLUSTER_WIDTH = 16;
   localparam int unsigned SIZE_WIDTH    = 32;
   localparam int unsigned COUNT_WIDTH   = 16;
   localparam int unsigned PREFIX_WIDTH  = 4;

   // Directory entry markers and attribute bits
   localparam logic [7:0] MARK_END       = 8'h00;
   localparam logic [7:0] MARK_DELETED   = 8'hE5;
   localparam logic [7:0] ATTR_KIND_MASK = 8'h0F;
   localparam int unsigned ATTR_DIR_BIT  = 4;

   // Register reset values
   localparam logic [PREFIX_WIDTH-1:0] PREFIX_LENGTH_RESET = 4'd8;
   localparam logic [COUNT_WIDTH-1:0]  TARGET_INDEX_RESET  = 16'd1;

   // Scan state after one entry
   typedef struct packed {
      status_type             status;
      logic [COUNT_WIDTH-1:0] count;
      logic [SIZE_WIDTH-1:0]  total;
      logic                   done;
   } eval_result_type;

endpackage

>>> hdl/fdes_eval.sv
// ----------------------------------------------------------------------------
// fdes_eval
// Classify one directory entry against the scan state and search settings.
// ----------------------------------------------------------------------------
module fdes_eval (
   input  logic                                 scan_start,
   input  logic [fdes_pkg::NAME_WIDTH-1:0]      entry_name,
   input  logic [fdes_pkg::EXT_WIDTH-1:0]       entry_ext,
   input  logic [fdes_pkg::ATTR_WIDTH-1:0]      entry_attrib,
   input  logic [fdes_pkg::SIZE_WIDTH-1:0]      entry_size,
   input  logic [fdes_pkg::COUNT_WIDTH-1:0]     count,
   input  logic [fdes_pkg::SIZE_WIDTH-1:0]      total,
   input  logic                                 done,
   input  fdes_pkg::mode_type                   search_mode,
   input  logic [fdes_pkg::NAME_WIDTH-1:0]      target_name,
   input  logic [fdes_pkg::EXT_WIDTH-1:0]       target_ext,
   input  logic [fdes_pkg::PREFIX_WIDTH-1:0]    prefix_length,
   input  logic [fdes_pkg::COUNT_WIDTH-1:0]     target_index,
   output fdes_pkg::eval_result_type            result
);

   logic [fdes_pkg::COUNT_WIDTH-1:0] base_count;
   logic [fdes_pkg::SIZE_WIDTH-1:0]  base_total;
   logic                             base_done;
   logic [fdes_pkg::COUNT_WIDTH-1:0] next_count;
   logic [7:0]                       lead;
   logic [fdes_pkg::NAME_BYTES-1:0]  byte_hit;
   logic                             prefix_hit;
   logic                             is_dir;
   logic                             hit;

   assign base_count = scan_start ? '0 : count;
   assign base_total = scan_start ? '0 : total;
   assign base_done  = scan_start ? 1'b0 : done;
   assign next_count = base_count + fdes_pkg::COUNT_WIDTH'(1);
   assign lead       = entry_name[fdes_pkg::NAME_WIDTH-1 -: 8];
   assign is_dir     = entry_attrib[fdes_pkg::ATTR_DIR_BIT];

   // Byte i (0 = first name byte) takes part when i < prefix length
   always_comb begin
      for (int i = 0; i < fdes_pkg::NAME_BYTES; i++) begin
         byte_hit[i] = (entry_name[fdes_pkg::NAME_WIDTH-1-8*i -: 8] ==
                        target_name[fdes_pkg::NAME_WIDTH-1-8*i -: 8]) ||
                       (prefix_length <= fdes_pkg::PREFIX_WIDTH'(i));
      end
   end
   assign prefix_hit = &byte_hit;

   always_comb begin
      case (search_mode)
         fdes_pkg::MODE_INDEX:  hit = (next_count == target_index);
         fdes_pkg::MODE_FILE:   hit = (entry_name == target_name) &&
                                      (entry_ext == target_ext);
         fdes_pkg::MODE_FOLDER: hit = is_dir && prefix_hit;
         default:               hit = 1'b0;
      endcase
   end

   always_comb begin
      result.count = base_count;
      result.total = base_total;
      result.done  = base_done;
      if (base_done) begin
         result.status = fdes_pkg::STATUS_DONE;
      end else if (lead == fdes_pkg::MARK_END) begin
         result.status = fdes_pkg::STATUS_END;
         result.done   = 1'b1;
      end else if ((lead == fdes_pkg::MARK_DELETED) ||
                   ((entry_attrib & fdes_pkg::ATTR_KIND_MASK) != '0)) begin
         result.status = fdes_pkg::STATUS_SKIPPED;
      end else begin
         result.count  = next_count;
         result.total  = base_total + entry_size;
         result.done   = hit;
         result.status = hit ? fdes_pkg::STATUS_MATCH : fdes_pkg::STATUS_COUNTED;
      end
   end

endmodule

>>> hdl/fat_directory_entry_scanner_core.sv
// ----------------------------------------------------------------------------
// fat_directory_entry_scanner_core
// FAT directory entry scanner: list, find by index, by name, by prefix.
// ----------------------------------------------------------------------------
// Usage:
//   Feed one decoded 32-byte directory entry per request on the req_ channel
//   (req_valid / req_stall). Each request yields exactly one result on the
//   rsp_ channel (rsp_valid / rsp_stall) carrying the status, running count,
//   running size total and the entry's own cluster, size and directory bit.
//   Set req_scan_start on the first entry of a directory to clear the count,
//   the total and the done flag before that entry is examined.
//   The csr_ port writes search settings; write it only while the block is
//   empty (no request in flight).
// Timing:
//   A request accepted into the input register is evaluated against the scan
//   state when it advances, and its result is loaded into the output register
//   as rsp_valid rises. Throughput is one request per cycle while rsp_stall is
//   low; the only loop is the count/total/done update, one adder wide.
// Reset:
//   Synchronous reset empties both registers, zeroes the scan state and sets
//   the settings to list mode, prefix length 8, target index 1.
// Stall:
//   While rsp_stall holds a result, the input register still takes a request
//   if empty; req_stall rises only when both stages are occupied and stuck.
// ----------------------------------------------------------------------------
module fat_directory_entry_scanner_core (
   input  logic                                    clock,
   input  logic                                    reset,
   // request channel
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_scan_start,
   input  logic [fdes_pkg::NAME_WIDTH-1:0]         req_entry_name,
   input  logic [fdes_pkg::EXT_WIDTH-1:0]          req_entry_ext,
   input  logic [fdes_pkg::ATTR_WIDTH-1:0]         req_entry_attrib,
   input  logic [fdes_pkg::CLUSTER_WIDTH-1:0]      req_cluster_high,
   input  logic [fdes_pkg::CLUSTER_WIDTH-1:0]      req_cluster_low,
   input  logic [fdes_pkg::SIZE_WIDTH-1:0]         req_entry_size,
   // result channel
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [2:0]                              rsp_status,
   output logic [fdes_pkg::COUNT_WIDTH-1:0]        rsp_entry_number,
   output logic [2*fdes_pkg::CLUSTER_WIDTH-1:0]    rsp_first_cluster,
   output logic [fdes_pkg::SIZE_WIDTH-1:0]         rsp_file_size,
   output logic [fdes_pkg::SIZE_WIDTH-1:0]         rsp_total_size,
   output logic                                    rsp_is_directory,
   // configuration port
   input  logic                                    csr_write_en,
   input  logic [fdes_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [fdes_pkg::CSR_DATA_WIDTH-1:0]     csr_data
);

   // Settings
   fdes_pkg::mode_type                  mode_ff;
   logic [fdes_pkg::NAME_WIDTH-1:0]     target_name_ff;
   logic [fdes_pkg::EXT_WIDTH-1:0]      target_ext_ff;
   logic [fdes_pkg::PREFIX_WIDTH-1:0]   prefix_length_ff;
   logic [fdes_pkg::COUNT_WIDTH-1:0]    target_index_ff;

   // Input register
   logic                                stage_valid_ff, stage_valid_in;
   logic                                stage_start_ff;
   logic [fdes_pkg::NAME_WIDTH-1:0]     stage_name_ff;
   logic [fdes_pkg::EXT_WIDTH-1:0]      stage_ext_ff;
   logic [fdes_pkg::ATTR_WIDTH-1:0]     stage_attrib_ff;
   logic [fdes_pkg::CLUSTER_WIDTH-1:0]  stage_chi_ff;
   logic [fdes_pkg::CLUSTER_WIDTH-1:0]  stage_clo_ff;
   logic [fdes_pkg::SIZE_WIDTH-1:0]     stage_size_ff;

   // Scan state
   logic [fdes_pkg::COUNT_WIDTH-1:0]    count_ff;
   logic [fdes_pkg::SIZE_WIDTH-1:0]     total_ff;
   logic                                done_ff;

   // Output register
   logic                                rsp_valid_ff, rsp_valid_in;
   fdes_pkg::status_type                rsp_status_ff;
   logic [fdes_pkg::COUNT_WIDTH-1:0]    rsp_count_ff;
   logic [2*fdes_pkg::CLUSTER_WIDTH-1:0] rsp_cluster_ff;
   logic [fdes_pkg::SIZE_WIDTH-1:0]     rsp_size_ff;
   logic [fdes_pkg::SIZE_WIDTH-1:0]     rsp_total_ff;
   logic                                rsp_dir_ff;

   fdes_pkg::eval_result_type           eval;
   logic                                req_accept;
   logic                                stage_adv;

   // Advance the input register whenever the output register is free or drains
   assign stage_adv  = stage_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = stage_valid_ff && !stage_adv;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_accept) begin
         stage_valid_in = 1'b1;
      end else if (stage_adv) begin
         stage_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (stage_adv) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   fdes_eval u_eval (
      .scan_start    (stage_start_ff),
      .entry_name    (stage_name_ff),
      .entry_ext     (stage_ext_ff),
      .entry_attrib  (stage_attrib_ff),
      .entry_size    (stage_size_ff),
      .count         (count_ff),
      .total         (total_ff),
      .done          (done_ff),
      .search_mode   (mode_ff),
      .target_name   (target_name_ff),
      .target_ext    (target_ext_ff),
      .prefix_length (prefix_length_ff),
      .target_index  (target_index_ff),
      .result        (eval)
   );

   // Settings: ignore writes to indexes past the last register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= fdes_pkg::MODE_LIST;
         target_name_ff   <= '0;
         target_ext_ff    <= '0;
         prefix_length_ff <= fdes_pkg::PREFIX_LENGTH_RESET;
         target_index_ff  <= fdes_pkg::TARGET_INDEX_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            fdes_pkg::CSR_SEARCH_MODE:
               mode_ff <= fdes_pkg::mode_type'(csr_data[1:0]);
            fdes_pkg::CSR_TARGET_NAME:
               target_name_ff <= csr_data;
            fdes_pkg::CSR_TARGET_EXT:
               target_ext_ff <= csr_data[fdes_pkg::EXT_WIDTH-1:0];
            fdes_pkg::CSR_PREFIX_LENGTH:
               prefix_length_ff <= csr_data[fdes_pkg::PREFIX_WIDTH-1:0];
            fdes_pkg::CSR_TARGET_INDEX:
               target_index_ff <= csr_data[fdes_pkg::COUNT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Control and scan state
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         count_ff       <= '0;
         total_ff       <= '0;
         done_ff        <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (stage_adv) begin
            count_ff <= eval.count;
            total_ff <= eval.total;
            done_ff  <= eval.done;
         end
      end
   end

   // Capture the request payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         stage_start_ff  <= req_scan_start;
         stage_name_ff   <= req_entry_name;
         stage_ext_ff    <= req_entry_ext;
         stage_attrib_ff <= req_entry_attrib;
         stage_chi_ff    <= req_cluster_high;
         stage_clo_ff    <= req_cluster_low;
         stage_size_ff   <= req_entry_size;
      end
   end

   // Load the result; hold it while the receiver stalls
   always_ff @(posedge clock) begin
      if (stage_adv) begin
         rsp_status_ff  <= eval.status;
         rsp_count_ff   <= eval.count;
         rsp_cluster_ff <= {stage_chi_ff, stage_clo_ff};
         rsp_size_ff    <= stage_size_ff;
         rsp_total_ff   <= eval.total;
         rsp_dir_ff     <= stage_attrib_ff[fdes_pkg::ATTR_DIR_BIT];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_entry_number  = rsp_count_ff;
   assign rsp_first_cluster = rsp_cluster_ff;
   assign rsp_file_size     = rsp_size_ff;
   assign rsp_total_size    = rsp_total_ff;
   assign rsp_is_directory  = rsp_dir_ff;

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the FAT directory entry scanner core.
// ----------------------------------------------------------------------------
// Streams decoded directory entries into the core and predicts every result
// with a behavioral copy of the scan state (count, size total, done flag) and
// of the search settings. Directed tests cover list mode, the three find
// modes, skipped and deleted slots, end markers, the done state and setting
// masking. Random directories then run under changing settings, with random
// gaps on the request side and random result stalls.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int unsigned CYCLE_LIMIT  = 2_000_000;
   localparam int unsigned RANDOM_ITEMS = 1750;
   localparam int unsigned MAX_REPORTS  = 10;

   // Shapes of generated directory entries
   typedef enum int {
      KIND_FILE,
      KIND_FOLDER,
      KIND_DELETED,
      KIND_LONG_NAME,
      KIND_ATTR_OTHER,
      KIND_END,
      KIND_TARGET,
      KIND_NOISE
   } entry_kind_type;

   typedef struct packed {
      logic                               scan_start;
      logic [fdes_pkg::NAME_WIDTH-1:0]    name;
      logic [fdes_pkg::EXT_WIDTH-1:0]     ext;
      logic [fdes_pkg::ATTR_WIDTH-1:0]    attrib;
      logic [fdes_pkg::CLUSTER_WIDTH-1:0] cluster_high;
      logic [fdes_pkg::CLUSTER_WIDTH-1:0] cluster_low;
      logic [fdes_pkg::SIZE_WIDTH-1:0]    size;
   } dir_entry_type;

   typedef struct packed {
      fdes_pkg::status_type                 status;
      logic [fdes_pkg::COUNT_WIDTH-1:0]     number;
      logic [2*fdes_pkg::CLUSTER_WIDTH-1:0] cluster;
      logic [fdes_pkg::SIZE_WIDTH-1:0]      size;
      logic [fdes_pkg::SIZE_WIDTH-1:0]      total;
      logic                                 is_dir;
   } scan_outcome_type;

   logic clock = 1'b0;
   logic reset;

   logic                                   req_valid;
   logic                                   req_stall;
   logic                                   req_scan_start;
   logic [fdes_pkg::NAME_WIDTH-1:0]        req_entry_name;
   logic [fdes_pkg::EXT_WIDTH-1:0]         req_entry_ext;
   logic [fdes_pkg::ATTR_WIDTH-1:0]        req_entry_attrib;
   logic [fdes_pkg::CLUSTER_WIDTH-1:0]     req_cluster_high;
   logic [fdes_pkg::CLUSTER_WIDTH-1:0]     req_cluster_low;
   logic [fdes_pkg::SIZE_WIDTH-1:0]        req_entry_size;
   logic                                   rsp_valid;
   logic                                   rsp_stall;
   logic [2:0]                             rsp_status;
   logic [fdes_pkg::COUNT_WIDTH-1:0]       rsp_entry_number;
   logic [2*fdes_pkg::CLUSTER_WIDTH-1:0]   rsp_first_cluster;
   logic [fdes_pkg::SIZE_WIDTH-1:0]        rsp_file_size;
   logic [fdes_pkg::SIZE_WIDTH-1:0]        rsp_total_size;
   logic                                   rsp_is_directory;
   logic                                   csr_write_en;
   logic [fdes_pkg::CSR_INDEX_WIDTH-1:0]   csr_index;
   logic [fdes_pkg::CSR_DATA_WIDTH-1:0]    csr_data;

   // Shadow copy of the search settings, updated on every register write
   fdes_pkg::mode_type                set_mode;
   logic [fdes_pkg::NAME_WIDTH-1:0]   set_name;
   logic [fdes_pkg::EXT_WIDTH-1:0]    set_ext;
   logic [fdes_pkg::PREFIX_WIDTH-1:0] set_prefix;
   logic [fdes_pkg::COUNT_WIDTH-1:0]  set_index;

   // Shadow copy of the scan state
   logic [fdes_pkg::COUNT_WIDTH-1:0] dir_count;
   logic [fdes_pkg::SIZE_WIDTH-1:0]  dir_total;
   logic                             dir_done;

   // Outcomes predicted for accepted requests, oldest first
   scan_outcome_type pending_outcomes[$];

   bit          idle_enable  = 1'b1;
   int unsigned calm_left    = 0;
   int unsigned stall_hold   = 0;
   int unsigned cycle_count  = 0;
   int unsigned entries_sent = 0;
   int unsigned requests_taken = 0;
   int unsigned results_checked = 0;
   int unsigned setting_writes = 0;
   int unsigned failures     = 0;
   int unsigned status_seen[5] = '{default: 0};

   fat_directory_entry_scanner_core u_dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Prediction
   // -------------------------------------------------------------------------

   // Leading-bytes mask for folder mode; zero bytes compares nothing and
   // anything above eight compares the whole name.
   function automatic logic [fdes_pkg::NAME_WIDTH-1:0] name_mask(
         input logic [fdes_pkg::PREFIX_WIDTH-1:0] len);
      int unsigned bytes;
      bytes = (len > fdes_pkg::NAME_BYTES) ? fdes_pkg::NAME_BYTES : len;
      if (bytes == 0)
         return '0;
      return {fdes_pkg::NAME_WIDTH{1'b1}} << (fdes_pkg::NAME_WIDTH - 8 * bytes);
   endfunction

   // Advance the shadow scan state by one entry and return its outcome.
   function automatic scan_outcome_type evaluate_entry(input dir_entry_type e);
      scan_outcome_type o;
      logic [fdes_pkg::NAME_WIDTH-1:0] mask;
      logic hit;
      hit = 1'b0;
      if (e.scan_start) begin
         dir_count = '0;
         dir_total = '0;
         dir_done  = 1'b0;
      end
      if (dir_done) begin
         o.status = fdes_pkg::STATUS_DONE;
      end else if (e.name[fdes_pkg::NAME_WIDTH-1 -: 8] == fdes_pkg::MARK_END) begin
         dir_done = 1'b1;
         o.status = fdes_pkg::STATUS_END;
      end else if (e.name[fdes_pkg::NAME_WIDTH-1 -: 8] == fdes_pkg::MARK_DELETED ||
                   (e.attrib & fdes_pkg::ATTR_KIND_MASK) != '0) begin
         o.status = fdes_pkg::STATUS_SKIPPED;
      end else begin
         dir_count = dir_count + 1'b1;
         dir_total = dir_total + e.size;
         case (set_mode)
            fdes_pkg::MODE_INDEX: begin
               hit = (dir_count == set_index);
            end
            fdes_pkg::MODE_FILE: begin
               hit = (e.name == set_name) && (e.ext == set_ext);
            end
            fdes_pkg::MODE_FOLDER: begin
               mask = name_mask(set_prefix);
               hit = e.attrib[fdes_pkg::ATTR_DIR_BIT] &&
                     ((e.name & mask) == (set_name & mask));
            end
            default: begin
               hit = 1'b0;
            end
         endcase
         if (hit) begin
            dir_done = 1'b1;
            o.status = fdes_pkg::STATUS_MATCH;
         end else begin
            o.status = fdes_pkg::STATUS_COUNTED;
         end
      end
      o.number  = dir_count;
      o.cluster = {e.cluster_high, e.cluster_low};
      o.size    = e.size;
      o.total   = dir_total;
      o.is_dir  = e.attrib[fdes_pkg::ATTR_DIR_BIT];
      return o;
   endfunction

   // -------------------------------------------------------------------------
   // Monitor: predict on every accepted request, check every accepted result
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      dir_entry_type    taken;
      scan_outcome_type want;
      scan_outcome_type got;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout at cycle %0d: %0d results still outstanding",
                  cycle_count, pending_outcomes.size());
         $display("Regression FAIL");
         $finish;
      end else if (!reset) begin
         // Push the prediction first so that the oldest entry stays in front
         // even if a result could come back in the same cycle.
         if (req_valid && !req_stall) begin
            taken = '{req_scan_start, req_entry_name, req_entry_ext, req_entry_attrib,
                      req_cluster_high, req_cluster_low, req_entry_size};
            pending_outcomes.push_back(evaluate_entry(taken));
            requests_taken++;
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{fdes_pkg::status_type'(rsp_status), rsp_entry_number,
                    rsp_first_cluster, rsp_file_size, rsp_total_size, rsp_is_directory};
            results_checked++;
            if (!$isunknown(rsp_status) && rsp_status <= 3'(fdes_pkg::STATUS_DONE))
               status_seen[rsp_status]++;
            if (pending_outcomes.size() == 0) begin
               failures++;
               if (failures <= MAX_REPORTS)
                  $display("cycle %0d: result with no request waiting: status %0d number %0d",
                           cycle_count, rsp_status, rsp_entry_number);
            end else begin
               want = pending_outcomes.pop_front();
               if (got !== want) begin
                  failures++;
                  if (failures <= MAX_REPORTS) begin
                     $display("cycle %0d: result %0d mismatch", cycle_count, results_checked);
                     $display("   expected status=%0d number=%0d cluster=%h size=%h total=%h dir=%b",
                              want.status, want.number, want.cluster, want.size, want.total,
                              want.is_dir);
                     $display("   actual   status=%0d number=%0d cluster=%h size=%h total=%h dir=%b",
                              got.status, got.number, got.cluster, got.size, got.total,
                              got.is_dir);
                  end
               end
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Result-side stalls: mostly short bursts, a few long holds, and calm
   // stretches so that back-to-back results also get through.
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      int unsigned r;
      if (!idle_enable) begin
         rsp_stall  = 1'b0;
         stall_hold = 0;
      end else if (stall_hold > 0) begin
         stall_hold--;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 10) begin
            rsp_stall  = 1'b0;
            stall_hold = $urandom_range(20, 60);
         end else if (r < 60) begin
            rsp_stall  = 1'b0;
            stall_hold = $urandom_range(0, 4);
         end else if (r < 93) begin
            rsp_stall  = 1'b1;
            stall_hold = $urandom_range(0, 2);
         end else begin
            rsp_stall  = 1'b1;
            stall_hold = $urandom_range(5, 20);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------

   // Idle cycles ahead of the next request: usually none or a few, now and
   // then a long pause, sometimes a run of requests with no gap at all.
   function automatic int unsigned next_gap();
      int unsigned r;
      if (!idle_enable)
         return 0;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 8) begin
         calm_left = $urandom_range(15, 60);
         return 0;
      end
      if (r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(4, 25);
   endfunction

   // Present one request at a falling edge and hold it until it is taken.
   // Valid stays high on return so that the next request can follow at once.
   task automatic send_entry(input dir_entry_type e);
      int unsigned gap;
      gap = next_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        = 1'b1;
      req_scan_start   = e.scan_start;
      req_entry_name   = e.name;
      req_entry_ext    = e.ext;
      req_entry_attrib = e.attrib;
      req_cluster_high = e.cluster_high;
      req_cluster_low  = e.cluster_low;
      req_entry_size   = e.size;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      entries_sent++;
   endtask

   // Drop valid and wait until every predicted result has come back.
   task automatic drain_results();
      req_valid = 1'b0;
      while (pending_outcomes.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Write one setting while the core is empty and mirror it in the shadow.
   task automatic write_setting(input logic [fdes_pkg::CSR_INDEX_WIDTH-1:0] index,
                                input logic [fdes_pkg::CSR_DATA_WIDTH-1:0] value);
      req_valid = 1'b0;
      while (pending_outcomes.size() != 0) @(negedge clock);
      csr_write_en = 1'b1;
      csr_index    = index;
      csr_data     = value;
      @(negedge clock);
      csr_write_en = 1'b0;
      setting_writes++;
      case (index)
         fdes_pkg::CSR_SEARCH_MODE:
            set_mode   = fdes_pkg::mode_type'(value[1:0]);
         fdes_pkg::CSR_TARGET_NAME:
            set_name   = value[fdes_pkg::NAME_WIDTH-1:0];
         fdes_pkg::CSR_TARGET_EXT:
            set_ext    = value[fdes_pkg::EXT_WIDTH-1:0];
         fdes_pkg::CSR_PREFIX_LENGTH:
            set_prefix = value[fdes_pkg::PREFIX_WIDTH-1:0];
         fdes_pkg::CSR_TARGET_INDEX:
            set_index  = value[fdes_pkg::COUNT_WIDTH-1:0];
         default: ;
      endcase
   endtask

   function automatic dir_entry_type pack_entry(
         input logic start,
         input logic [fdes_pkg::NAME_WIDTH-1:0] name,
         input logic [fdes_pkg::EXT_WIDTH-1:0] ext,
         input logic [fdes_pkg::ATTR_WIDTH-1:0] attrib,
         input logic [2*fdes_pkg::CLUSTER_WIDTH-1:0] cluster,
         input logic [fdes_pkg::SIZE_WIDTH-1:0] size);
      return '{start, name, ext, attrib, cluster[31:16], cluster[15:0], size};
   endfunction

   // Build a random entry of the given shape. Target entries copy the name
   // sought under the current settings so that find modes actually hit.
   function automatic dir_entry_type make_entry(input entry_kind_type kind,
                                                input logic start);
      dir_entry_type e;
      logic [fdes_pkg::NAME_WIDTH-1:0] mask;
      logic [7:0] lead;
      do lead = 8'($urandom_range(1, 255)); while (lead == fdes_pkg::MARK_DELETED);
      e.scan_start   = start;
      e.name         = {lead, 56'({$urandom, $urandom})};
      e.ext          = 24'($urandom);
      e.attrib       = {4'($urandom), 4'h0};
      e.cluster_high = 16'($urandom);
      e.cluster_low  = 16'($urandom);
      e.size         = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 4096)) : $urandom;
      case (kind)
         KIND_FILE: begin
            e.attrib[fdes_pkg::ATTR_DIR_BIT] = 1'b0;
         end
         KIND_FOLDER: begin
            e.attrib[fdes_pkg::ATTR_DIR_BIT] = 1'b1;
         end
         KIND_DELETED: begin
            e.name[fdes_pkg::NAME_WIDTH-1 -: 8] = fdes_pkg::MARK_DELETED;
            e.attrib = 8'($urandom);
         end
         KIND_LONG_NAME: begin
            e.attrib = fdes_pkg::ATTR_KIND_MASK;
         end
         KIND_ATTR_OTHER: begin
            e.attrib = 8'($urandom);
            if ((e.attrib & fdes_pkg::ATTR_KIND_MASK) == '0)
               e.attrib[0] = 1'b1;
         end
         KIND_END: begin
            e.name[fdes_pkg::NAME_WIDTH-1 -: 8] = fdes_pkg::MARK_END;
            e.attrib = 8'($urandom);
         end
         KIND_TARGET: begin
            if (set_mode == fdes_pkg::MODE_FOLDER) begin
               mask = name_mask(set_prefix);
               e.name = (set_name & mask) | (e.name & ~mask);
               e.attrib[fdes_pkg::ATTR_DIR_BIT] = 1'b1;
            end else begin
               e.name = set_name;
               e.ext  = set_ext;
            end
         end
         default: begin
            // noise: anything at all, including a stray scan start
            e.scan_start = ($urandom_range(0, 7) == 0);
            e.name       = {$urandom, $urandom};
            e.attrib     = 8'($urandom);
            e.size       = $urandom;
         end
      endcase
      return e;
   endfunction

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Settings straight out of reset (list mode): field extremes, total wrap,
   // skipped slots, end marker, done state and scan start on an end marker.
   task automatic test_list_defaults();
      send_entry(pack_entry(1'b1, '1, '1, 8'hF0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_entry(pack_entry(1'b0, "README  ", "TXT", 8'h20, 32'h0000_0003, 32'h0000_0001));
      send_entry(pack_entry(1'b0, {fdes_pkg::MARK_DELETED, "LDFILE "}, "BAK", 8'h20,
                            32'h0001_0000, 32'd77));
      send_entry(pack_entry(1'b0, "LONGNAME", "XYZ", fdes_pkg::ATTR_KIND_MASK, 32'h0, 32'h0));
      send_entry(pack_entry(1'b0, "RDONLY  ", "DAT", 8'h01, 32'h0000_1234, 32'd512));
      send_entry(pack_entry(1'b0, {fdes_pkg::MARK_END, "ENDMARK"}, '0, '0, '0, '0));
      send_entry(pack_entry(1'b0, "LATE    ", "TXT", 8'h00, 32'h0000_0042, 32'd99));
      send_entry(pack_entry(1'b1, {fdes_pkg::MARK_END, "RESTART"}, "ZZZ", 8'h10,
                            32'hABCD_0001, 32'd5));
      send_entry(pack_entry(1'b1, "BOOT    ", "BIN", 8'h00, 32'h0000_0002, 32'd4096));
   endtask

   // Index mode first relies on the reset target of one, then seeks the third.
   task automatic test_find_by_index();
      write_setting(fdes_pkg::CSR_SEARCH_MODE,
                    fdes_pkg::CSR_DATA_WIDTH'(fdes_pkg::MODE_INDEX));
      send_entry(pack_entry(1'b1, "FIRST   ", "TXT", 8'h20, 32'h10, 32'd10));
      send_entry(pack_entry(1'b0, "SECOND  ", "TXT", 8'h20, 32'h11, 32'd20));
      write_setting(fdes_pkg::CSR_TARGET_INDEX, 64'd3);
      send_entry(pack_entry(1'b1, {fdes_pkg::MARK_DELETED, "ONEGONE"}, "TXT", 8'h20,
                            32'h20, 32'd1));
      send_entry(pack_entry(1'b0, "ALPHA   ", "DOC", 8'h20, 32'h21, 32'd2));
      send_entry(pack_entry(1'b0, "ALPHALFN", "   ", fdes_pkg::ATTR_KIND_MASK, 32'h0, 32'd0));
      send_entry(pack_entry(1'b0, "BRAVO   ", "   ", 8'h10, 32'h22, 32'd0));
      send_entry(pack_entry(1'b0, "CHARLIE ", "LOG", 8'h20, 32'h23, 32'd3));
   endtask

   // Exact 8+3 match: a near miss on the extension, then the hit.
   task automatic test_find_file();
      write_setting(fdes_pkg::CSR_TARGET_NAME, "KERNEL  ");
      write_setting(fdes_pkg::CSR_TARGET_EXT, "SYS");
      write_setting(fdes_pkg::CSR_SEARCH_MODE,
                    fdes_pkg::CSR_DATA_WIDTH'(fdes_pkg::MODE_FILE));
      send_entry(pack_entry(1'b1, "KERNEL  ", "SYB", 8'h20, 32'h30, 32'd1000));
      send_entry(pack_entry(1'b0, "KERNEL  ", "SYS", 8'h20, 32'h31, 32'd2000));
   endtask

   // Prefix match on directories only; then prefix zero (any directory hits)
   // and a length above eight (whole name compared).
   task automatic test_find_folder();
      write_setting(fdes_pkg::CSR_TARGET_NAME, "GAMESXYZ");
      write_setting(fdes_pkg::CSR_PREFIX_LENGTH, 64'd5);
      write_setting(fdes_pkg::CSR_SEARCH_MODE,
                    fdes_pkg::CSR_DATA_WIDTH'(fdes_pkg::MODE_FOLDER));
      send_entry(pack_entry(1'b1, "GAMES   ", "   ", 8'h20, 32'h40, 32'd1));
      send_entry(pack_entry(1'b0, "GAMER   ", "   ", 8'h10, 32'h41, 32'd0));
      send_entry(pack_entry(1'b0, "GAMESAVE", "   ", 8'h10, 32'h42, 32'd0));
      write_setting(fdes_pkg::CSR_PREFIX_LENGTH, 64'd0);
      send_entry(pack_entry(1'b1, "ZZZ     ", "   ", 8'h10, 32'h43, 32'd0));
      write_setting(fdes_pkg::CSR_PREFIX_LENGTH, 64'd15);
      send_entry(pack_entry(1'b1, "GAMESXYQ", "   ", 8'h10, 32'h44, 32'd0));
      send_entry(pack_entry(1'b0, "GAMESXYZ", "   ", 8'h30, 32'h45, 32'd0));
   endtask

   // High data bits beyond a register's width are dropped, and writes to
   // unused indexes change nothing.
   task automatic test_setting_extras();
      write_setting(fdes_pkg::CSR_SEARCH_MODE,
                    {62'h3FFF_FFFF_FFFF_FFFF, 2'(fdes_pkg::MODE_LIST)});
      for (int i = fdes_pkg::CSR_TARGET_INDEX + 1; i < 2 ** fdes_pkg::CSR_INDEX_WIDTH; i++)
         write_setting(fdes_pkg::CSR_INDEX_WIDTH'(i), '1);
      send_entry(pack_entry(1'b1, "CHECK   ", "CFG", 8'h00, 32'h50, 32'd8));
   endtask

   // Phases of random settings, each followed by well-formed directories with
   // random content, salted with deleted slots, long-name slots, noise,
   // missing scan starts and items sent after the scan is over.
   task automatic test_random_scans();
      logic [fdes_pkg::CSR_DATA_WIDTH-1:0] junk;
      logic [fdes_pkg::NAME_WIDTH-1:0]     name;
      logic [fdes_pkg::PREFIX_WIDTH-1:0]   prefix;
      logic [fdes_pkg::COUNT_WIDTH-1:0]    index;
      entry_kind_type                      kind;
      int unsigned goal;
      int unsigned phase_end;
      int unsigned len;
      int unsigned r;
      goal = entries_sent + RANDOM_ITEMS;
      while (entries_sent < goal) begin
         // pick new settings, extremes now and then, junk in the unused bits
         junk = {$urandom, $urandom};
         r = $urandom_range(0, 9);
         name = (r == 0) ? '0 : (r == 1) ? '1 : {$urandom, $urandom};
         if (r > 1 && (name[fdes_pkg::NAME_WIDTH-1 -: 8] == fdes_pkg::MARK_END ||
                       name[fdes_pkg::NAME_WIDTH-1 -: 8] == fdes_pkg::MARK_DELETED))
            name[fdes_pkg::NAME_WIDTH-1 -: 8] = "A";
         write_setting(fdes_pkg::CSR_SEARCH_MODE, {junk[63:2], 2'($urandom)});
         write_setting(fdes_pkg::CSR_TARGET_NAME, name);
         r = $urandom_range(0, 9);
         write_setting(fdes_pkg::CSR_TARGET_EXT, {junk[63:24], (r == 0) ? 24'h0 :
                                                  (r == 1) ? 24'hFF_FFFF : 24'($urandom)});
         r = $urandom_range(0, 9);
         prefix = (r < 2) ? 4'($urandom) : (r == 2) ? 4'd1 : (r == 3) ? 4'd8 :
                  4'($urandom_range(1, 8));
         write_setting(fdes_pkg::CSR_PREFIX_LENGTH, {junk[63:4], prefix});
         r = $urandom_range(0, 9);
         index = (r == 0) ? 16'hFFFF : (r == 1) ? 16'd1 : 16'($urandom_range(1, 24));
         write_setting(fdes_pkg::CSR_TARGET_INDEX, {junk[63:16], index});

         phase_end = entries_sent + $urandom_range(80, 200);
         while (entries_sent < phase_end && entries_sent < goal) begin
            len = $urandom_range(2, 30);
            for (int i = 0; i < len; i++) begin
               r = $urandom_range(0, 99);
               if (r < 35)      kind = KIND_FILE;
               else if (r < 55) kind = KIND_FOLDER;
               else if (r < 65) kind = KIND_DELETED;
               else if (r < 73) kind = KIND_LONG_NAME;
               else if (r < 78) kind = KIND_ATTR_OTHER;
               else if (r < 90) kind = KIND_TARGET;
               else if (r < 96) kind = KIND_NOISE;
               else             kind = KIND_END;
               // open most directories with a scan start
               send_entry(make_entry(kind, i == 0 && $urandom_range(0, 9) != 0));
            end
            // close with an end marker and sometimes keep talking past it
            if ($urandom_range(0, 3) != 0)
               send_entry(make_entry(KIND_END, 1'b0));
            repeat ($urandom_range(0, 2))
               send_entry(make_entry(KIND_FILE, 1'b0));
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Sequence
   // -------------------------------------------------------------------------
   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_scan_start   = 1'b0;
      req_entry_name   = '0;
      req_entry_ext    = '0;
      req_entry_attrib = '0;
      req_cluster_high = '0;
      req_cluster_low  = '0;
      req_entry_size   = '0;
      rsp_stall        = 1'b0;
      csr_write_en     = 1'b0;
      csr_index        = '0;
      csr_data         = '0;
      set_mode         = fdes_pkg::MODE_LIST;
      set_name         = '0;
      set_ext          = '0;
      set_prefix       = fdes_pkg::PREFIX_LENGTH_RESET;
      set_index        = fdes_pkg::TARGET_INDEX_RESET;
      dir_count        = '0;
      dir_total        = '0;
      dir_done         = 1'b0;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      test_list_defaults();
      test_find_by_index();
      test_find_file();
      test_find_folder();
      test_setting_extras();
      test_random_scans();

      drain_results();
      repeat (8) @(negedge clock);
      $display("Scanned %0d entries (%0d taken) under %0d setting writes; %0d results checked.",
               entries_sent, requests_taken, setting_writes, results_checked);
      $display("Outcomes: %0d skipped, %0d counted, %0d matched, %0d end, %0d after done;",
               status_seen[fdes_pkg::STATUS_SKIPPED], status_seen[fdes_pkg::STATUS_COUNTED],
               status_seen[fdes_pkg::STATUS_MATCH], status_seen[fdes_pkg::STATUS_END],
               status_seen[fdes_pkg::STATUS_DONE]);
      $display("%0d failures.", failures);
      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
